>>> hw/rtl/ssig_pkg.sv
// ----------------------------------------------------------------------------
// Strided slice index generator package
// Shared sizes, register and mode codes, the pipeline record and the helper
// that pulls one axis slot out of a packed configuration register.
// ----------------------------------------------------------------------------
package ssig_pkg;

  // Tensor geometry.
  localparam int MAX_AXES   = 4;
  localparam int LEN_BITS   = 16;
  localparam int INDEX_BITS = 32;

  // Fixed field widths.
  localparam int POS_W     = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 3;
  localparam int AXC_W     = 3;

  // Arithmetic widths. A source coordinate is start + coord * stride, so its
  // magnitude is at most 2^(2*LEN_BITS-1).
  localparam int SRC_W    = 2 * LEN_BITS + 2;
  localparam int MAG_W    = 2 * LEN_BITS;
  localparam int DIV_STEP = 4;
  localparam int DIV_ST   = (POS_W + DIV_STEP - 1) / DIV_STEP;
  localparam int MOD_ST   = (MAG_W + DIV_STEP - 1) / DIV_STEP;
  localparam int SUM_W    = ((INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS) + 1;

  // Pipeline stage map.
  localparam int ST_DIV  = 1;
  localparam int ST_C0   = ST_DIV + (MAX_AXES - 1) * DIV_ST;
  localparam int ST_MUL  = ST_C0 + 1;
  localparam int ST_ADD  = ST_MUL + 1;
  localparam int ST_ABS  = ST_ADD + 1;
  localparam int ST_MOD  = ST_ABS + 1;
  localparam int ST_FIX  = ST_MOD + MOD_ST;
  localparam int ST_SEL  = ST_FIX + 1;
  localparam int ST_FOLD = ST_SEL + 1;
  localparam int NST     = ST_FOLD + 2 * MAX_AXES;

  // Sample modes.
  localparam logic [MODE_W-1:0] MODE_WRAP    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLAMP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REFLECT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FILL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STRICT  = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LENGTHS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LENGTHS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSETS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZES     = 3'd5;

  // One item as it moves down the pipeline.
  typedef struct packed {
    logic [POS_W-1:0]                     work;
    logic [LEN_BITS-1:0]                  rem;
    logic [MAX_AXES-1:0][LEN_BITS-1:0]    coord;
    logic                                 bad;
    logic [MAX_AXES-1:0][SRC_W-1:0]       src;
    logic [MAX_AXES-1:0][MAG_W-1:0]       mag;
    logic [MAX_AXES-1:0]                  neg;
    logic [MAX_AXES-1:0][LEN_BITS:0]      mrem;
    logic [MAX_AXES-1:0][LEN_BITS-1:0]    c;
    logic                                 fill;
    logic                                 err;
    logic [INDEX_BITS-1:0]                flat;
  } pipe_t;

  // Slot of an axis in a packed register; axis 0 sits in the top bits and
  // slots beyond the register read as zero.
  function automatic logic [LEN_BITS-1:0] slot_of(input logic [CFG_W-1:0] r,
                                                  input int axis);
    logic [CFG_W+LEN_BITS-1:0] ext;
    int sh;
    ext = {{LEN_BITS{1'b0}}, r};
    sh  = (MAX_AXES - 1 - axis) * LEN_BITS;
    if (sh >= CFG_W) return '0;
    return ext[sh +: LEN_BITS];
  endfunction

endpackage

>>> hw/rtl/strided_slice_index_generator.sv
// ----------------------------------------------------------------------------
// Strided slice index generator
// Turns a flat output position of a strided multi-axis slice into the flat
// input index to gather from, with wrap, clamp, reflect, fill or strict
// handling of coordinates that fall outside the input tensor.
// ----------------------------------------------------------------------------
// The block takes one position and gives one result every clock cycle while
// the result side does not stall. The pipelined long division splits the
// position into coordinates, four quotient bits per stage over three axes.
// The signed modulo remaps each coordinate. The saturating fold takes two
// stages per axis. A stall on the result side holds the whole pipeline.
// Configuration must only be written while no item is in flight.
module strided_slice_index_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssig_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           pos_valid,
  output logic                           pos_stall,
  input  logic [ssig_pkg::POS_W-1:0]     out_position,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [ssig_pkg::OUT_W-1:0]     source_index,
  output logic                           fill_flag,
  output logic                           error_flag
);
  import ssig_pkg::*;

  logic [MODE_W-1:0] sample_mode;
  logic [AXC_W-1:0]  axis_count;
  logic [CFG_W-1:0]  input_lengths;
  logic [CFG_W-1:0]  output_lengths;
  logic [CFG_W-1:0]  start_offsets;
  logic [CFG_W-1:0]  step_sizes;

  logic [MODE_W-1:0]                  mode_n;
  logic [MAX_AXES-1:0]                axis_used;
  logic [MAX_AXES-1:0][LEN_BITS-1:0]  in_len;
  logic [MAX_AXES-1:0][LEN_BITS-1:0]  out_len;
  logic [MAX_AXES-1:0][LEN_BITS-1:0]  start_v;
  logic [MAX_AXES-1:0][LEN_BITS-1:0]  step_v;
  logic [MAX_AXES-1:0][LEN_BITS:0]    divr;

  pipe_t            p   [NST];
  pipe_t            nxt [NST];
  logic [NST-1:0]   v;
  logic             en;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode    <= MODE_STRICT;
      axis_count     <= AXC_W'(MAX_AXES);
      input_lengths  <= '0;
      output_lengths <= '0;
      start_offsets  <= '0;
      step_sizes     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_MODE:    sample_mode    <= cfg_data[MODE_W-1:0];
        REG_AXIS_COUNT:     axis_count     <= cfg_data[AXC_W-1:0];
        REG_INPUT_LENGTHS:  input_lengths  <= cfg_data;
        REG_OUTPUT_LENGTHS: output_lengths <= cfg_data;
        REG_START_OFFSETS:  start_offsets  <= cfg_data;
        REG_STEP_SIZES:     step_sizes     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Settled view of the configuration: effective mode, axes in use, slots.
  always_comb begin
    int n;
    n = int'(axis_count);
    if (n < 1) n = 1;
    if (n > MAX_AXES) n = MAX_AXES;
    mode_n = (sample_mode > MODE_STRICT) ? MODE_STRICT : sample_mode;
    for (int d = 0; d < MAX_AXES; d++) begin
      axis_used[d] = (d < n);
      in_len[d]    = slot_of(input_lengths, d);
      out_len[d]   = slot_of(output_lengths, d);
      start_v[d]   = slot_of(start_offsets, d);
      step_v[d]    = slot_of(step_sizes, d);
      divr[d]      = (mode_n == MODE_REFLECT) ? ({in_len[d], 1'b0} - (LEN_BITS+1)'(2))
                                              : {1'b0, in_len[d]};
    end
  end

  // The whole pipeline moves unless a finished result is held back.
  assign en        = !(v[NST-1] && res_stall);
  assign pos_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], pos_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) p[k] <= nxt[k];
    end
  end

  // Entry stage.
  always_comb begin
    nxt[0]      = '0;
    nxt[0].work = out_position;
  end

  // Long division of the position by each inner output length, innermost
  // first; the quotient replaces the dividend bit by bit.
  for (genvar j = 0; j < MAX_AXES - 1; j++) begin : g_div_axis
    localparam int D = MAX_AXES - 1 - j;
    for (genvar s = 0; s < DIV_ST; s++) begin : g_div_st
      localparam int K = ST_DIV + j * DIV_ST + s;
      always_comb begin
        logic [LEN_BITS:0] t;
        int b;
        t = '0;
        b = 0;
        nxt[K] = p[K-1];
        if (s == 0) nxt[K].rem = '0;
        if (axis_used[D]) begin
          for (int i = 0; i < DIV_STEP; i++) begin
            b = POS_W - 1 - (s * DIV_STEP + i);
            if (b >= 0) begin
              t = {nxt[K].rem, nxt[K].work[b]};
              if (t >= {1'b0, out_len[D]}) begin
                t = t - {1'b0, out_len[D]};
                nxt[K].work[b] = 1'b1;
              end else begin
                nxt[K].work[b] = 1'b0;
              end
              nxt[K].rem = t[LEN_BITS-1:0];
            end
          end
          if (s == DIV_ST - 1) nxt[K].coord[D] = nxt[K].rem;
        end
      end
    end
  end

  // Outer coordinate is what is left; past total when it reaches the outer
  // length or when any used length is zero.
  always_comb begin
    nxt[ST_C0]          = p[ST_C0-1];
    nxt[ST_C0].coord[0] = nxt[ST_C0].work[LEN_BITS-1:0];
    nxt[ST_C0].bad      = (nxt[ST_C0].work >= POS_W'(out_len[0]));
    for (int d = 0; d < MAX_AXES; d++) begin
      if (axis_used[d] && out_len[d] == '0) nxt[ST_C0].bad = 1'b1;
    end
  end

  // Coordinate times stride.
  always_comb begin
    logic signed [LEN_BITS:0]   cs;
    logic signed [LEN_BITS-1:0] ss;
    logic signed [2*LEN_BITS:0] pr;
    logic signed [SRC_W-1:0]    sx;
    nxt[ST_MUL] = p[ST_MUL-1];
    for (int d = 0; d < MAX_AXES; d++) begin
      cs = $signed({1'b0, p[ST_MUL-1].coord[d]});
      ss = $signed(step_v[d]);
      pr = (2*LEN_BITS+1)'(cs) * (2*LEN_BITS+1)'(ss);
      sx = SRC_W'(pr);
      nxt[ST_MUL].src[d] = sx;
    end
  end

  // Plus start.
  always_comb begin
    logic signed [SRC_W-1:0]    a;
    logic signed [LEN_BITS-1:0] st;
    logic signed [SRC_W-1:0]    b;
    nxt[ST_ADD] = p[ST_ADD-1];
    for (int d = 0; d < MAX_AXES; d++) begin
      a  = $signed(p[ST_ADD-1].src[d]);
      st = $signed(start_v[d]);
      b  = SRC_W'(st);
      nxt[ST_ADD].src[d] = a + b;
    end
  end

  // Sign and magnitude for the modulo.
  always_comb begin
    logic signed [SRC_W-1:0] a;
    logic [SRC_W-1:0]        m;
    nxt[ST_ABS] = p[ST_ABS-1];
    for (int d = 0; d < MAX_AXES; d++) begin
      a = $signed(p[ST_ABS-1].src[d]);
      m = (a < 0) ? SRC_W'(-a) : SRC_W'(a);
      nxt[ST_ABS].neg[d]  = (a < 0);
      nxt[ST_ABS].mag[d]  = m[MAG_W-1:0];
      nxt[ST_ABS].mrem[d] = '0;
    end
  end

  // Remainder of the magnitude by the wrap length or the reflect period.
  for (genvar s = 0; s < MOD_ST; s++) begin : g_mod_st
    localparam int K = ST_MOD + s;
    always_comb begin
      logic [LEN_BITS+1:0] t;
      int b;
      t = '0;
      b = 0;
      nxt[K] = p[K-1];
      for (int d = 0; d < MAX_AXES; d++) begin
        for (int i = 0; i < DIV_STEP; i++) begin
          b = MAG_W - 1 - (s * DIV_STEP + i);
          if (b >= 0) begin
            t = {nxt[K].mrem[d], nxt[K].mag[d][b]};
            if (t >= {1'b0, divr[d]}) t = t - {1'b0, divr[d]};
            nxt[K].mrem[d] = t[LEN_BITS:0];
          end
        end
      end
    end
  end

  // Turn the remainder of a negative value into a positive one.
  always_comb begin
    nxt[ST_FIX] = p[ST_FIX-1];
    for (int d = 0; d < MAX_AXES; d++) begin
      if (p[ST_FIX-1].neg[d] && p[ST_FIX-1].mrem[d] != '0) begin
        nxt[ST_FIX].mrem[d] = divr[d] - p[ST_FIX-1].mrem[d];
      end
    end
  end

  // Apply the sample mode to each used axis.
  always_comb begin
    logic signed [SRC_W-1:0] a;
    logic signed [SRC_W-1:0] lx;
    logic                    oob;
    logic [LEN_BITS:0]       r;
    nxt[ST_SEL]      = p[ST_SEL-1];
    nxt[ST_SEL].fill = 1'b0;
    nxt[ST_SEL].err  = 1'b0;
    nxt[ST_SEL].flat = '0;
    for (int d = 0; d < MAX_AXES; d++) begin
      a   = $signed(p[ST_SEL-1].src[d]);
      lx  = $signed(SRC_W'(in_len[d]));
      oob = (a < 0) || (a >= lx);
      r   = p[ST_SEL-1].mrem[d];
      nxt[ST_SEL].c[d] = '0;
      if (axis_used[d]) begin
        unique case (mode_n)
          MODE_WRAP: begin
            if (in_len[d] != '0) nxt[ST_SEL].c[d] = r[LEN_BITS-1:0];
          end
          MODE_CLAMP: begin
            if (in_len[d] == '0 || a < 0) nxt[ST_SEL].c[d] = '0;
            else if (oob) nxt[ST_SEL].c[d] = in_len[d] - LEN_BITS'(1);
            else nxt[ST_SEL].c[d] = a[LEN_BITS-1:0];
          end
          MODE_REFLECT: begin
            if (in_len[d] > LEN_BITS'(1)) begin
              if (r < {1'b0, in_len[d]}) nxt[ST_SEL].c[d] = r[LEN_BITS-1:0];
              else nxt[ST_SEL].c[d] = LEN_BITS'(divr[d] - r);
            end
          end
          MODE_FILL: begin
            if (oob) nxt[ST_SEL].fill = 1'b1;
            else nxt[ST_SEL].c[d] = a[LEN_BITS-1:0];
          end
          default: begin
            if (oob) nxt[ST_SEL].err = 1'b1;
            else nxt[ST_SEL].c[d] = a[LEN_BITS-1:0];
          end
        endcase
      end
    end
  end

  // Saturating row-major fold, a multiply stage and an add stage per axis.
  for (genvar d = 0; d < MAX_AXES; d++) begin : g_fold
    localparam int KM = ST_FOLD + 2 * d;
    localparam int KA = KM + 1;
    always_comb begin
      logic [INDEX_BITS+LEN_BITS-1:0] pr;
      pr = (INDEX_BITS+LEN_BITS)'(p[KM-1].flat) * (INDEX_BITS+LEN_BITS)'(in_len[d]);
      nxt[KM] = p[KM-1];
      if (axis_used[d]) begin
        if (pr[INDEX_BITS+LEN_BITS-1:INDEX_BITS] != '0) nxt[KM].flat = '1;
        else nxt[KM].flat = pr[INDEX_BITS-1:0];
      end
    end
    always_comb begin
      logic [SUM_W-1:0] sm;
      sm = SUM_W'(p[KA-1].flat) + SUM_W'(p[KA-1].c[d]);
      nxt[KA] = p[KA-1];
      if (axis_used[d]) begin
        if (sm > SUM_W'({INDEX_BITS{1'b1}})) nxt[KA].flat = '1;
        else nxt[KA].flat = sm[INDEX_BITS-1:0];
      end
    end
  end

  // Result of the last stage; an error clears index and fill.
  assign res_valid    = v[NST-1];
  assign error_flag   = p[NST-1].bad || p[NST-1].err;
  assign fill_flag    = !error_flag && p[NST-1].fill;
  assign source_index = error_flag ? '0 : OUT_W'(p[NST-1].flat);

`ifndef NO_ASSERTIONS
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_flag |-> source_index == '0 && !fill_flag)
    else $error("error result carries an index or fill");

  a_fill_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && fill_flag |-> mode_n == MODE_FILL)
    else $error("fill flag outside fill mode");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> pos_stall)
    else $error("input taken while result is held");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(source_index))
    else $error("held result lost or changed");
`endif

endmodule

>>> tb/sv/strided_slice_index_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strided slice index checker
// Watches the configuration, position and result channels of the index
// generator, keeps its own copy of the slice geometry, predicts the gather
// index for every accepted position and compares each result transfer.
// ----------------------------------------------------------------------------
module strided_slice_index_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ssig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssig_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           pos_valid,
  input  logic                           pos_stall,
  input  logic [ssig_pkg::POS_W-1:0]     out_position,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic [ssig_pkg::OUT_W-1:0]     source_index,
  input  logic                           fill_flag,
  input  logic                           error_flag,
  output int                             fail_count,
  output int                             pending_count
);
  import ssig_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] index;
    logic             fill;
    logic             err;
  } gather_t;

  localparam logic [63:0] INDEX_SAT = (64'd1 << INDEX_BITS) - 64'd1;

  // Local copy of the geometry registers.
  logic [MODE_W-1:0] geo_mode;
  logic [AXC_W-1:0]  geo_axes;
  logic [CFG_W-1:0]  geo_in_len;
  logic [CFG_W-1:0]  geo_out_len;
  logic [CFG_W-1:0]  geo_start;
  logic [CFG_W-1:0]  geo_step;

  gather_t gathers_due[$];

  function automatic logic [LEN_BITS-1:0] lane(input logic [CFG_W-1:0] r, input int axis);
    return r[(MAX_AXES - 1 - axis) * LEN_BITS +: LEN_BITS];
  endfunction

  function automatic longint floor_mod(input longint a, input longint m);
    longint r;
    r = a % m;
    return (r < 0) ? r + m : r;
  endfunction

  // Expected gather index for one output position under the current geometry.
  function automatic gather_t predict_gather(input logic [POS_W-1:0] p);
    gather_t g;
    int n;
    logic [63:0] total, rest, flat, olen;
    logic [63:0] coord [MAX_AXES];
    logic [MODE_W-1:0] md;
    logic signed [LEN_BITS-1:0] st, sp;
    longint len, src, c, period, m;
    bit oob;
    g.index = '0;
    g.fill = 1'b0;
    g.err = 1'b0;
    n = (geo_axes < 1) ? 1 : ((geo_axes > MAX_AXES) ? MAX_AXES : int'(geo_axes));
    md = (geo_mode > MODE_STRICT) ? MODE_STRICT : geo_mode;
    total = 64'd1;
    for (int d = 0; d < n; d++) total = total * lane(geo_out_len, d);
    if (64'(p) >= total) begin
      g.err = 1'b1;
      return g;
    end
    // Split the position into output coordinates, innermost axis first.
    rest = 64'(p);
    for (int d = n - 1; d >= 0; d--) begin
      olen = lane(geo_out_len, d);
      coord[d] = rest % olen;
      rest = rest / olen;
    end
    flat = '0;
    for (int d = 0; d < n; d++) begin
      len = longint'(lane(geo_in_len, d));
      st = lane(geo_start, d);
      sp = lane(geo_step, d);
      src = longint'(st) + longint'(coord[d]) * longint'(sp);
      oob = (src < 0) || (src >= len);
      c = 0;
      case (md)
        MODE_WRAP: c = (len > 0) ? floor_mod(src, len) : 0;
        MODE_CLAMP: c = (len > 0) ? ((src < 0) ? 0 : ((src >= len) ? len - 1 : src)) : 0;
        MODE_REFLECT: begin
          if (len > 1) begin
            period = 2 * (len - 1);
            m = floor_mod(src, period);
            c = (m < len) ? m : period - m;
          end
        end
        MODE_FILL: begin
          if (oob) g.fill = 1'b1;
          else c = src;
        end
        default: begin
          if (oob) g.err = 1'b1;
          else c = src;
        end
      endcase
      // Saturating row-major fold.
      if (flat != 0 && 64'(len) > INDEX_SAT / flat) flat = INDEX_SAT;
      else flat = flat * 64'(len);
      if (64'(c) > INDEX_SAT - flat) flat = INDEX_SAT;
      else flat = flat + 64'(c);
    end
    if (g.err) begin
      g.fill = 1'b0;
      return g;
    end
    g.index = flat[OUT_W-1:0];
    return g;
  endfunction

  assign pending_count = gathers_due.size();

  // Track register writes, predict accepted positions and check results.
  always @(posedge clk) begin
    gather_t want;
    if (rst) begin
      fail_count = 0;
      geo_mode <= MODE_STRICT;
      geo_axes <= AXC_W'(MAX_AXES);
      geo_in_len <= '0;
      geo_out_len <= '0;
      geo_start <= '0;
      geo_step <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_MODE: geo_mode <= cfg_data[MODE_W-1:0];
          REG_AXIS_COUNT: geo_axes <= cfg_data[AXC_W-1:0];
          REG_INPUT_LENGTHS: geo_in_len <= cfg_data;
          REG_OUTPUT_LENGTHS: geo_out_len <= cfg_data;
          REG_START_OFFSETS: geo_start <= cfg_data;
          REG_STEP_SIZES: geo_step <= cfg_data;
          default: ;
        endcase
      end
      if (pos_valid && !pos_stall) gathers_due = {gathers_due, predict_gather(out_position)};
      if (res_valid && !res_stall) begin
        if (gathers_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: index %h fill %b err %b",
                     source_index, fill_flag, error_flag);
        end else begin
          want = gathers_due.pop_front();
          if (want.index !== source_index || want.fill !== fill_flag ||
              want.err !== error_flag) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected index %h fill %b err %b, got %h %b %b",
                       want.index, want.fill, want.err, source_index, fill_flag,
                       error_flag);
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/strided_slice_index_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strided slice index generator testbench
// Programs a series of slice geometries, from directed corner cases to random
// ones, streams output positions through the generator with bursty input and
// random result stalls, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module strided_slice_index_generator_tb;
  import ssig_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 650;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 pos_valid = 1'b0;
  logic                 pos_stall;
  logic [POS_W-1:0]     out_position = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [OUT_W-1:0]     source_index;
  logic                 fill_flag;
  logic                 error_flag;
  int                   fail_count;
  int                   pending_count;
  int                   cycles = 0;

  // Sender burst state and receiver stall pattern.
  int burst_left = 0;
  int stall_kind = 0;
  int stall_left = 0;

  // Current geometry as programmed, used to aim positions at the slice.
  logic [CFG_W-1:0] cur_out_len;
  logic [AXC_W-1:0] cur_axes;

  strided_slice_index_generator dut (.*);

  strided_slice_index_checker checker_u (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls on a random pattern that is picked anew when the last one runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 128);
    end else begin
      stall_left <= stall_left - 1;
    end
    res_stall <= (stall_kind == 0) ? 1'b0 : ($urandom_range(0, 3) < stall_kind);
  end

  // One register transfer; the valid stays high for a following write and the
  // caller drops it when the sequence of writes is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_OUTPUT_LENGTHS) cur_out_len = val;
    if (idx == REG_AXIS_COUNT) cur_axes = val[AXC_W-1:0];
  endtask

  task automatic program_geometry(input logic [2:0] mode, input logic [2:0] axes,
                                  input logic [63:0] in_len, input logic [63:0] out_len,
                                  input logic [63:0] start, input logic [63:0] step);
    write_reg(REG_SAMPLE_MODE, 64'(mode));
    write_reg(REG_AXIS_COUNT, 64'(axes));
    write_reg(REG_INPUT_LENGTHS, in_len);
    write_reg(REG_OUTPUT_LENGTHS, out_len);
    write_reg(REG_START_OFFSETS, start);
    write_reg(REG_STEP_SIZES, step);
    cfg_valid <= 1'b0;
  endtask

  // One position transfer; the valid stays high within a burst.
  task automatic send_position(input logic [POS_W-1:0] p);
    pos_valid <= 1'b1;
    out_position <= p;
    do @(posedge clk); while (pos_stall);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        pos_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    pos_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] slice_total();
    int n;
    logic [63:0] t;
    n = (cur_axes < 1) ? 1 : ((cur_axes > MAX_AXES) ? MAX_AXES : int'(cur_axes));
    t = 64'd1;
    for (int d = 0; d < n; d++) t = t * cur_out_len[(MAX_AXES - 1 - d) * LEN_BITS +: LEN_BITS];
    return t;
  endfunction

  // Random packed register; small lanes mostly, with zero and full-width lanes.
  function automatic logic [63:0] rand_lanes(input bit signed_lanes);
    logic [63:0] r;
    int k;
    for (int d = 0; d < MAX_AXES; d++) begin
      k = $urandom_range(0, 15);
      if (k == 0) r[d * LEN_BITS +: LEN_BITS] = 16'($urandom());
      else if (k == 1) r[d * LEN_BITS +: LEN_BITS] = signed_lanes ? 16'h8000 : 16'hFFFF;
      else if (k == 2 && !signed_lanes) r[d * LEN_BITS +: LEN_BITS] = '0;
      else if (signed_lanes) r[d * LEN_BITS +: LEN_BITS] = 16'($signed($urandom_range(0, 20)) - 10);
      else r[d * LEN_BITS +: LEN_BITS] = 16'($urandom_range(1, 7));
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] aimed_position();
    logic [63:0] t;
    t = slice_total();
    if ($urandom_range(0, 7) == 0) return $urandom();
    if (t > 64'hFFFF_FFF0) return $urandom();
    return $urandom_range(0, 32'(t) + 1);
  endfunction

  initial begin
    int sent;
    int phase_len;
    cur_out_len = '0;
    cur_axes = 3'd4;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: every output length is zero, so every position is past total.
    send_position(32'h0000_0000);
    send_position(32'hFFFF_FFFF);
    drain();

    // Every mode on a small slice whose coordinates run off both ends.
    for (int md = MODE_WRAP; md <= 7; md++) begin
      program_geometry(3'(md), 3'd4, {16'd4, 16'd5, 16'd6, 16'd7},
                       {16'd2, 16'd3, 16'd4, 16'd5}, {-16'sd2, 16'sd1, 16'sd3, -16'sd1},
                       {16'sd3, -16'sd2, 16'sd2, 16'sd2});
      send_position(32'd0);
      send_position(32'd119);
      if (md <= MODE_STRICT) send_position(32'd120);
      drain();
    end

    // Reflect on a length-one axis and a zero input length under fill.
    program_geometry(MODE_REFLECT, 3'd2, {16'd1, 16'd0, 32'd0}, {16'd3, 16'd2, 32'd0},
                     {16'sd5, 16'sd0, 32'd0}, {16'sd1, 16'sd1, 32'd0});
    send_position(32'd5);
    drain();
    write_reg(REG_SAMPLE_MODE, 64'(MODE_FILL));
    cfg_valid <= 1'b0;
    send_position(32'd3);
    drain();

    // Wide lengths saturate the index; axis count zero acts as one.
    program_geometry(MODE_CLAMP, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000);
    send_position(32'hFFFF_FFFF);
    send_position(32'd0);
    drain();
    program_geometry(MODE_WRAP, 3'd0, 64'hFFFF_0000_0000_0000, 64'h0010_0000_0000_0000,
                     64'h8000_0000_0000_0000, 64'h7FFF_0000_0000_0000);
    send_position(32'd15);
    drain();

    // Random geometries with positions aimed mostly inside the slice.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      program_geometry(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_lanes(1'b0),
                       rand_lanes(1'b0), rand_lanes(1'b1), rand_lanes(1'b1));
      phase_len = $urandom_range(20, 50);
      for (int i = 0; i < phase_len; i++) begin
        send_position(aimed_position());
        // Hold the sender once until everything in flight has come back.
        if (sent + i == RANDOM_ITEMS / 2) drain();
      end
      sent += phase_len;
      drain();
    end

    repeat (NST + 20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
